// ===== design/cdo_pkg.sv =====
`timescale 1ns / 1ps

package cdo_pkg;

    localparam logic [13:0] YEAR_MIN   = 14'd1;
    localparam logic [13:0] YEAR_MAX   = 14'd9999;
    localparam logic [3:0]  MONTH_JAN  = 4'd1;
    localparam logic [3:0]  MONTH_FEB  = 4'd2;
    localparam logic [3:0]  MONTH_DEC  = 4'd12;
    localparam logic [4:0]  DAY_FIRST  = 5'd1;
    localparam logic [4:0]  DAY_DEC_31 = 5'd31;

    // x / 100 == (x * DIV100_MUL) >> DIV100_SHIFT, exact for x < 43690
    localparam logic [13:0] DIV100_MUL   = 14'd5243;
    localparam int          DIV100_SHIFT = 19;
    // x / 7 is (x * DIV7_MUL) >> 16 or one less, for x < 16384
    localparam logic [13:0] DIV7_MUL     = 14'd9362;
    localparam int          DIV7_SHIFT   = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEAP_MUL,
        ST_LEAP_RES,
        ST_CLAMP,
        ST_WALK,
        ST_WD_MUL,
        ST_WD_SUM,
        ST_WD_MOD_MUL,
        ST_WD_MOD_RES
    } cdo_state_t;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic        year_chg;
        logic        oor;
    } cdo_step_t;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // (3 * (m + 1)) / 5 for shifted months 3..14
    function automatic logic [3:0] zeller_term(input logic [3:0] m);
        logic [3:0] t;
        case (m)
            4'd3:    t = 4'd2;
            4'd4:    t = 4'd3;
            4'd5:    t = 4'd3;
            4'd6:    t = 4'd4;
            4'd7:    t = 4'd4;
            4'd8:    t = 4'd5;
            4'd9:    t = 4'd6;
            4'd10:   t = 4'd6;
            4'd11:   t = 4'd7;
            4'd12:   t = 4'd7;
            4'd13:   t = 4'd8;
            4'd14:   t = 4'd9;
            default: t = 4'd0;
        endcase
        return t;
    endfunction

endpackage

// ===== design/calendar_date_day_offset_core.sv =====
`timescale 1ns / 1ps
// A request runs the leap check, the day clamp, the walk and the weekday steps.
// The walk steps one day per cycle but redoes the leap check at each new year.
// Throughput: one request at a time; busy stays high until done pulses.
// done pulses for one cycle with the result; the receiver cannot stall.
// rst_n is asynchronous, active low, and returns the block to idle.

module calendar_date_day_offset_core
    import cdo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        kind,
    input  logic [4:0]  start_day,
    input  logic [3:0]  start_month,
    input  logic [13:0] start_year,
    input  logic [15:0] day_count,
    output logic        done,
    output logic [4:0]  result_day,
    output logic [3:0]  result_month,
    output logic [13:0] result_year,
    output logic [2:0]  weekday,
    output logic        leap_year,
    output logic        out_of_range
);

    cdo_state_t  state_reg, state_next;
    logic        done_reg, done_next;

    logic        back_reg, back_next;
    logic [4:0]  day_reg, day_next;
    logic [3:0]  month_reg, month_next;
    logic [13:0] year_reg, year_next;
    logic [15:0] cnt_reg, cnt_next;
    logic        leap_reg, leap_next;
    logic        oor_reg, oor_next;
    logic        clamp_reg, clamp_next;
    logic [3:0]  mp_reg, mp_next;
    logic [13:0] yp_reg, yp_next;
    logic [13:0] k_reg, k_next;
    logic [27:0] prod_reg;
    logic [2:0]  wd_reg, wd_next;

    logic [13:0] mul_op;
    logic [13:0] mul_k;
    logic [27:0] prod_next;

    cdo_step_t   step;
    logic [4:0]  len;
    logic [8:0]  q100;
    logic [13:0] q100_x;
    logic [13:0] r100;
    logic [11:0] q7;
    logic [14:0] q7_x;
    logic [3:0]  r7;
    logic [2:0]  r7_fix;
    logic        early;
    logic [13:0] yp_cur;
    logic [3:0]  mp_cur;

    cdo_day_step u_step (
        .back  (back_reg),
        .day   (day_reg),
        .month (month_reg),
        .year  (year_reg),
        .leap  (leap_reg),
        .step  (step)
    );

    assign len    = month_len(month_reg, leap_reg);
    assign q100   = prod_reg[DIV100_SHIFT +: 9];
    assign q100_x = 14'({q100, 6'b0}) + 14'({q100, 5'b0}) + 14'({q100, 2'b0});
    assign r100   = year_reg - q100_x;
    assign q7     = prod_reg[DIV7_SHIFT +: 12];
    assign q7_x   = 15'({q7, 3'b0}) - 15'(q7);
    assign r7     = 4'(15'(k_reg) - q7_x);
    assign r7_fix = (r7 >= 4'd7) ? 3'(r7 - 4'd7) : r7[2:0];
    assign early  = (month_reg <= MONTH_FEB);
    assign yp_cur = early ? (year_reg - 14'd1) : year_reg;
    assign mp_cur = early ? (month_reg + 4'd12) : month_reg;

    // shared constant multiplier
    assign prod_next = 28'(mul_op) * 28'(mul_k);

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        back_next  = back_reg;
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        cnt_next   = cnt_reg;
        leap_next  = leap_reg;
        oor_next   = oor_reg;
        clamp_next = clamp_reg;
        mp_next    = mp_reg;
        yp_next    = yp_reg;
        k_next     = k_reg;
        wd_next    = wd_reg;
        mul_op     = year_reg;
        mul_k      = DIV100_MUL;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    back_next  = kind;
                    day_next   = start_day;
                    cnt_next   = day_count;
                    oor_next   = 1'b0;
                    clamp_next = 1'b1;
                    if (start_month < MONTH_JAN)
                        month_next = MONTH_JAN;
                    else if (start_month > MONTH_DEC)
                        month_next = MONTH_DEC;
                    else
                        month_next = start_month;
                    if (start_year < YEAR_MIN)
                        year_next = YEAR_MIN;
                    else if (start_year > YEAR_MAX)
                        year_next = YEAR_MAX;
                    else
                        year_next = start_year;
                    state_next = ST_LEAP_MUL;
                end
            end
            ST_LEAP_MUL:
            begin
                state_next = ST_LEAP_RES;
            end
            ST_LEAP_RES:
            begin
                leap_next  = (year_reg[1:0] == 2'b00) &&
                             ((r100 != 14'd0) || (q100[1:0] == 2'b00));
                state_next = clamp_reg ? ST_CLAMP : ST_WALK;
            end
            ST_CLAMP:
            begin
                clamp_next = 1'b0;
                if (day_reg < DAY_FIRST)
                    day_next = DAY_FIRST;
                else if (day_reg > len)
                    day_next = len;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (cnt_reg == 16'd0)
                begin
                    state_next = ST_WD_MUL;
                end
                else if (step.oor)
                begin
                    oor_next   = 1'b1;
                    state_next = ST_WD_MUL;
                end
                else
                begin
                    cnt_next   = cnt_reg - 16'd1;
                    day_next   = step.day;
                    month_next = step.month;
                    year_next  = step.year;
                    if (step.year_chg)
                        state_next = ST_LEAP_MUL;
                end
            end
            ST_WD_MUL:
            begin
                mul_op     = yp_cur;
                yp_next    = yp_cur;
                mp_next    = mp_cur;
                state_next = ST_WD_SUM;
            end
            ST_WD_SUM:
            begin
                k_next = 14'(day_reg) + 14'({mp_reg, 1'b0}) + 14'(zeller_term(mp_reg))
                       + yp_reg + (yp_reg >> 2) - 14'(q100) + 14'(q100[8:2]) + 14'd2;
                state_next = ST_WD_MOD_MUL;
            end
            ST_WD_MOD_MUL:
            begin
                mul_op     = k_reg;
                mul_k      = DIV7_MUL;
                state_next = ST_WD_MOD_RES;
            end
            ST_WD_MOD_RES:
            begin
                wd_next    = (r7_fix == 3'd0) ? 3'd7 : r7_fix;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        back_reg  <= back_next;
        day_reg   <= day_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        cnt_reg   <= cnt_next;
        leap_reg  <= leap_next;
        oor_reg   <= oor_next;
        clamp_reg <= clamp_next;
        mp_reg    <= mp_next;
        yp_reg    <= yp_next;
        k_reg     <= k_next;
        wd_reg    <= wd_next;
        prod_reg  <= prod_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign result_day   = day_reg;
    assign result_month = month_reg;
    assign result_year  = year_reg;
    assign weekday      = wd_reg;
    assign leap_year    = leap_reg;
    assign out_of_range = oor_reg;

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_done_after_mod: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == ST_WD_MOD_RES)
        else $error("done without weekday reduction");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request not taken");

    a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (weekday != 3'd0) && (result_month >= MONTH_JAN) && (result_month <= MONTH_DEC))
        else $error("result out of range");

    a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && state_next == ST_WALK) |=> cnt_reg == $past(cnt_reg) - 16'd1)
        else $error("walk count slip");
`endif

endmodule

// ===== design/cdo_day_step.sv =====
`timescale 1ns / 1ps

module cdo_day_step
    import cdo_pkg::*;
(
    input  logic        back,
    input  logic [4:0]  day,
    input  logic [3:0]  month,
    input  logic [13:0] year,
    input  logic        leap,
    output cdo_step_t   step
);

    logic [4:0] len;
    logic [3:0] prev_month;

    assign len        = month_len(month, leap);
    assign prev_month = month - 4'd1;

    always_comb
    begin
        step          = '0;
        step.day      = day;
        step.month    = month;
        step.year     = year;
        if (!back)
        begin
            if (day < len)
            begin
                step.day = day + 5'd1;
            end
            else if (month == MONTH_DEC)
            begin
                if (year >= YEAR_MAX)
                begin
                    step.oor = 1'b1;
                end
                else
                begin
                    step.day      = DAY_FIRST;
                    step.month    = MONTH_JAN;
                    step.year     = year + 14'd1;
                    step.year_chg = 1'b1;
                end
            end
            else
            begin
                step.day   = DAY_FIRST;
                step.month = month + 4'd1;
            end
        end
        else
        begin
            if (day > DAY_FIRST)
            begin
                step.day = day - 5'd1;
            end
            else if (month == MONTH_JAN)
            begin
                if (year <= YEAR_MIN)
                begin
                    step.oor = 1'b1;
                end
                else
                begin
                    step.day      = DAY_DEC_31;
                    step.month    = MONTH_DEC;
                    step.year     = year - 14'd1;
                    step.year_chg = 1'b1;
                end
            end
            else
            begin
                step.month = prev_month;
                step.day   = month_len(prev_month, leap);
            end
        end
    end

endmodule
